@@ design/shsc_pkg.sv @@
// Shared types and constants for the stepper half-step command controller.
// Used by the controller, the datapath and the top level.
package shsc_pkg;

   // Item kinds on the request channel
   localparam logic OpByte = 1'b0;
   localparam logic OpTick = 1'b1;

   // Run direction codes carried in packet byte 1
   localparam logic [7:0] DirBack     = 8'd0;
   localparam logic [7:0] DirFwd      = 8'd1;
   localparam logic [7:0] DirOnceBack = 8'd2;
   localparam logic [7:0] DirOnceFwd  = 8'd3;

   // Byte positions within a five-byte packet
   localparam logic [2:0] IdxDir   = 3'd1;
   localparam logic [2:0] IdxHi    = 3'd2;
   localparam logic [2:0] IdxLo    = 3'd3;
   localparam logic [2:0] IdxLast  = 3'd4;

   // Step period limits in ticks, and the minimum running speed
   localparam logic [17:0] PeriodMax    = 18'd200000;
   localparam logic [17:0] PeriodMin    = 18'd20000;
   localparam logic [15:0] RunThreshold = 16'd3277;

   // 200000 / 65535 = 3 + 3395 / 65535
   localparam logic [11:0] FracCoef = 12'd3395;

   // Half-step coil patterns, bit0 = coil A .. bit3 = coil D
   localparam logic [3:0] CoilTable [8] = '{
      4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
   };

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request beat
      logic exec;      // apply the item and load the response register
      logic mul;       // form the fractional period product
      logic fin;       // finish the period division and store it
   } shsc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pkt_done;  // the latched item is the last byte of a packet
   } shsc_stat_type;

endpackage

@@ design/shsc_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing beyond plain logic types.
interface shsc_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface shsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coils;
   logic [2:0] phase_now;
   logic       stepped;

   modport source (output valid, output coils, output phase_now, output stepped, input ready);
   modport sink   (input valid, input coils, input phase_now, input stepped, output ready);
endinterface

@@ design/shsc_ctrl.sv @@
// Sequencing state machine: accepts one beat at a time, schedules the item update,
// the response register load and the two-step period calculation. Uses shsc_pkg.
module shsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output shsc_pkg::shsc_cmd_type  cmd,
   input  shsc_pkg::shsc_stat_type stat
);
   import shsc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Response register can take a beat when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = stat.pkt_done ? ST_MUL : ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a response that is still waiting
   a_exec_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // Commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   // Period product is always followed by the division step
   a_mul_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.fin)
      else $error("period calculation broken off");

   // A request beat always leads to a response beat before the next request
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready)
      else $error("new beat taken before response");

endmodule

@@ design/shsc_dp.sv @@
// Datapath: item latch, packet assembly, drive state, tick countdown, period
// arithmetic and the response register. Driven by shsc_ctrl commands; uses shsc_pkg.
module shsc_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_operation,
   input  logic [7:0]              req_data_byte,
   output logic [3:0]              rsp_coils,
   output logic [2:0]              rsp_phase_now,
   output logic                    rsp_stepped,
   input  shsc_pkg::shsc_cmd_type  cmd,
   output shsc_pkg::shsc_stat_type stat
);
   import shsc_pkg::*;

   // Latched request beat
   logic        op_ff;
   logic [7:0]  byte_ff;

   // Motor and packet state
   logic [2:0]  phase_ff, phase_in;
   logic        energized_ff, energized_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  pend_dir_ff, pend_dir_in;
   logic [7:0]  pend_hi_ff, pend_hi_in;
   logic [7:0]  pend_lo_ff, pend_lo_in;
   logic [7:0]  run_dir_ff, run_dir_in;
   logic        running_ff, running_in;
   logic [17:0] period_ff, period_in;
   logic [17:0] countdown_ff, countdown_in;

   // Period arithmetic
   logic [15:0] speed;
   logic [15:0] diff;
   logic [27:0] prod_ff;
   logic [28:0] quot_sum;
   logic [17:0] period_raw;

   // Response register
   logic [3:0]  coils_ff;
   logic [2:0]  phase_now_ff;
   logic        stepped_ff;
   logic        moved;

   assign stat.pkt_done = (op_ff == OpByte) && (byte_index_ff >= IdxLast);

   assign speed = {pend_hi_ff, pend_lo_ff};
   assign diff  = ~speed;

   // floor(y / 65535) = (y + (y >> 16) + 1) >> 16 for y below 2^32 - 1
   assign quot_sum   = {1'b0, prod_ff} + 29'(prod_ff[27:16]) + 29'd1;
   assign period_raw = 18'(diff) + 18'({diff, 1'b0}) + 18'(quot_sum[28:16]);

   // Apply the latched item to the state
   always_comb begin
      phase_in      = phase_ff;
      energized_in  = energized_ff;
      byte_index_in = byte_index_ff;
      pend_dir_in   = pend_dir_ff;
      pend_hi_in    = pend_hi_ff;
      pend_lo_in    = pend_lo_ff;
      run_dir_in    = run_dir_ff;
      running_in    = running_ff;
      countdown_in  = countdown_ff;
      period_in     = period_ff;
      moved         = 1'b0;
      if (cmd.exec) begin
         if (op_ff == OpByte) begin
            case (byte_index_ff)
               IdxDir:  pend_dir_in = byte_ff;
               IdxHi:   pend_hi_in  = byte_ff;
               IdxLo:   pend_lo_in  = byte_ff;
               default: ;
            endcase
            if (byte_index_ff >= IdxLast) begin
               // Close the packet: take direction, one-shot steps, run flag
               byte_index_in = '0;
               run_dir_in    = pend_dir_ff;
               running_in    = (speed >= RunThreshold);
               if (pend_dir_ff == DirOnceBack) begin
                  phase_in     = phase_ff - 3'd1;
                  energized_in = 1'b1;
                  moved        = 1'b1;
               end else if (pend_dir_ff == DirOnceFwd) begin
                  phase_in     = phase_ff + 3'd1;
                  energized_in = 1'b1;
                  moved        = 1'b1;
               end
            end else begin
               byte_index_in = byte_index_ff + 3'd1;
            end
         end else begin
            if (countdown_ff <= 18'd1) begin
               // Expiry: reload, and step while running forward or back
               countdown_in = period_ff;
               if (running_ff && !(run_dir_ff inside {DirOnceBack, DirOnceFwd})) begin
                  energized_in = 1'b1;
                  if (run_dir_ff == DirFwd) begin
                     phase_in = phase_ff + 3'd1;
                     moved    = 1'b1;
                  end else if (run_dir_ff == DirBack) begin
                     phase_in = phase_ff - 3'd1;
                     moved    = 1'b1;
                  end
               end
            end else begin
               countdown_in = countdown_ff - 18'd1;
            end
         end
      end
      // Store the new period, clamped at the fast end
      if (cmd.fin) begin
         period_in = (period_raw < PeriodMin) ? PeriodMin : period_raw;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         energized_ff  <= 1'b0;
         byte_index_ff <= '0;
         run_dir_ff    <= DirBack;
         running_ff    <= 1'b0;
         period_ff     <= PeriodMax;
         countdown_ff  <= PeriodMax;
      end else begin
         phase_ff      <= phase_in;
         energized_ff  <= energized_in;
         byte_index_ff <= byte_index_in;
         run_dir_ff    <= run_dir_in;
         running_ff    <= running_in;
         period_ff     <= period_in;
         countdown_ff  <= countdown_in;
      end
   end

   // Payload registers: beat latch, pending bytes, product, response
   always_ff @(posedge clock) begin
      pend_dir_ff <= pend_dir_in;
      pend_hi_ff  <= pend_hi_in;
      pend_lo_ff  <= pend_lo_in;
      if (cmd.capture) begin
         op_ff   <= req_operation;
         byte_ff <= req_data_byte;
      end
      if (cmd.mul) begin
         prod_ff <= 28'(FracCoef) * 28'(diff);
      end
      if (cmd.exec) begin
         coils_ff     <= energized_in ? CoilTable[phase_in] : 4'h0;
         phase_now_ff <= phase_in;
         stepped_ff   <= moved;
      end
   end

   assign rsp_coils     = coils_ff;
   assign rsp_phase_now = phase_now_ff;
   assign rsp_stepped   = stepped_ff;

endmodule

@@ design/stepper_half_step_command_controller_top.sv @@
// Stepper half-step command controller, top level.
// Depends on shsc_pkg, shsc_if, shsc_ctrl and shsc_dp.
//
// Request channel (req_if): each beat is either a received serial byte
// (operation 0) or one time tick (operation 1). Five bytes form a packet:
// byte 1 is the run direction, bytes 2 and 3 the big-endian speed word.
// Response channel (rsp_if): exactly one beat per request beat, carrying the
// coil pattern, the current half-step phase and whether the item stepped.
//
// Each request beat is latched, then applied as the response register is
// loaded. Items do not overlap: no new beat is taken until the current one
// is done, and the last byte of a packet also runs the period divide by
// 65535 as a multiply then a reciprocal-add step in the datapath.
// Reset (synchronous, active high) stops the motor, de-energizes it, and sets
// phase 0, a 200000-tick period and countdown; response regs are not reset.
// A stalled receiver holds the response register; the block finishes the
// current item only once the register frees up, then takes the next beat.
module stepper_half_step_command_controller_top (
   input logic         clock,
   input logic         reset,
   shsc_req_if.sink    req_if,
   shsc_rsp_if.source  rsp_if
);
   import shsc_pkg::*;

   shsc_cmd_type  cmd;
   shsc_stat_type stat;

   shsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   shsc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_if.operation),
      .req_data_byte (req_if.data_byte),
      .rsp_coils     (rsp_if.coils),
      .rsp_phase_now (rsp_if.phase_now),
      .rsp_stepped   (rsp_if.stepped),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule
